// ----- hw/rtl/two_axis_pid_servo_balancer_assert.svh -----
// Assertion macros for the two-axis PID servo balancer.
`ifndef TWO_AXIS_PID_SERVO_BALANCER_ASSERT_SVH
`define TWO_AXIS_PID_SERVO_BALANCER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BAL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two_axis_pid_servo_balancer: check failed");
// Next-cycle implication, checked out of reset.
`define BAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("two_axis_pid_servo_balancer: check failed");
`else
`define BAL_ASSERT_IMP(label, ante, cons)
`define BAL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/tapsb_pkg.sv -----
// Types, constants and the angle-to-pulse function of the servo balancer.
`default_nettype none
package tapsb_pkg;

  typedef struct packed {
    logic [7:0]  req_type;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pulse_one;
    logic [11:0] pulse_two;
    logic [11:0] pulse_three;
    logic [11:0] pulse_four;
  } out_item_t;

  // command opcodes
  localparam logic [7:0] OP_ANGLE    = 8'd10;
  localparam logic [7:0] OP_POSITION = 8'd50;
  localparam logic [7:0] OP_TARGET   = 8'd100;
  localparam logic [7:0] OP_REST     = 8'd150;

  // internal command kinds
  localparam logic [1:0] KIND_ANGLE = 2'd0;
  localparam logic [1:0] KIND_POS   = 2'd1;
  localparam logic [1:0] KIND_TGT   = 2'd2;
  localparam logic [1:0] KIND_REST  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_GAIN_P_X = 3'd0;
  localparam logic [2:0] REG_GAIN_D_X = 3'd1;
  localparam logic [2:0] REG_GAIN_I_X = 3'd2;
  localparam logic [2:0] REG_GAIN_P_Y = 3'd3;
  localparam logic [2:0] REG_GAIN_D_Y = 3'd4;
  localparam logic [2:0] REG_GAIN_I_Y = 3'd5;
  localparam logic [2:0] REG_DEAD_BAND = 3'd6;
  localparam logic [2:0] REG_DRIVE_LIMIT = 3'd7;

  localparam logic [23:0] GAIN_P_RST = 24'd3932;
  localparam logic [23:0] GAIN_D_RST = 24'd52429;
  localparam logic [23:0] GAIN_I_RST = 24'd66;
  localparam logic [15:0] DEAD_BAND_RST = 16'd30;
  localparam logic [7:0]  DRIVE_LIMIT_RST = 8'd50;
  localparam logic [15:0] TARGET_X_RST = 16'd320;
  localparam logic [15:0] TARGET_Y_RST = 16'd240;

  localparam logic [8:0]  REST_ANGLE = 9'd5;
  localparam logic [8:0]  MAX_ANGLE  = 9'd180;
  localparam logic [11:0] REST_PULSE = 12'd555;
  localparam logic [11:0] PULSE_BASE = 12'd500;
  // ceil(2^19 * 100 / 9): floor(a*100/9) == (a*PULSE_RECIP) >> 19 for a <= 180
  localparam logic [22:0] PULSE_RECIP = 23'd5825423;
  localparam logic [15:0] TRUNC_BIAS = 16'hFFFF;

  function automatic logic [11:0] angle_to_pulse(input logic [7:0] angle);
    logic [30:0] prod;
    prod = 31'(angle) * 31'(PULSE_RECIP);
    return PULSE_BASE + prod[30:19];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/two_axis_pid_servo_balancer.sv -----
// Top level of the two-axis PID servo balancer: config registers and PID pipeline.
`default_nettype none
`include "two_axis_pid_servo_balancer_assert.svh"
// Two-axis ball balancer. Each input transfer is one decoded command frame;
// opcodes 10 (angle), 50 (ball position), 100 (target) and 150 (rest) each give
// one output transfer carrying the current pulse width of all four servos, any
// other opcode is swallowed with no output. The datapath is a six-register
// pipeline: input register, error/integral stage (ball, target, last error and
// integral state are updated here), gain multiplies, product sum, truncate and
// clamp, then pulse conversion into the output register, which also holds the
// servo pulse state. An item is accepted every cycle when nothing downstream is
// stalled, and its result moves through each register in turn to the output.
// Any empty stage lets the input side keep accepting while a result waits on
// out_stall. Config registers sit at byte address 4*index on the APB port;
// write them only when the block is idle.
module two_axis_pid_servo_balancer
  import tapsb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------- config
  logic [23:0] gain_p_r [2];
  logic [23:0] gain_d_r [2];
  logic [23:0] gain_i_r [2];
  logic [15:0] dead_band_r;
  logic [7:0]  drive_limit_r;
  logic [2:0]  reg_idx;
  logic        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r[0]   <= GAIN_P_RST;
      gain_d_r[0]   <= GAIN_D_RST;
      gain_i_r[0]   <= GAIN_I_RST;
      gain_p_r[1]   <= GAIN_P_RST;
      gain_d_r[1]   <= GAIN_D_RST;
      gain_i_r[1]   <= GAIN_I_RST;
      dead_band_r   <= DEAD_BAND_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_GAIN_P_X:    gain_p_r[0]   <= pwdata[23:0];
        REG_GAIN_D_X:    gain_d_r[0]   <= pwdata[23:0];
        REG_GAIN_I_X:    gain_i_r[0]   <= pwdata[23:0];
        REG_GAIN_P_Y:    gain_p_r[1]   <= pwdata[23:0];
        REG_GAIN_D_Y:    gain_d_r[1]   <= pwdata[23:0];
        REG_GAIN_I_Y:    gain_i_r[1]   <= pwdata[23:0];
        REG_DEAD_BAND:   dead_band_r   <= pwdata[15:0];
        REG_DRIVE_LIMIT: drive_limit_r <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P_X:    prdata = {8'd0, gain_p_r[0]};
      REG_GAIN_D_X:    prdata = {8'd0, gain_d_r[0]};
      REG_GAIN_I_X:    prdata = {8'd0, gain_i_r[0]};
      REG_GAIN_P_Y:    prdata = {8'd0, gain_p_r[1]};
      REG_GAIN_D_Y:    prdata = {8'd0, gain_d_r[1]};
      REG_GAIN_I_Y:    prdata = {8'd0, gain_i_r[1]};
      REG_DEAD_BAND:   prdata = {16'd0, dead_band_r};
      REG_DRIVE_LIMIT: prdata = {24'd0, drive_limit_r};
    endcase
  end

  // ------------------------------------------------------- pipeline control
  logic v0_r, v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic s0_move, pulse_load;
  logic in_known;
  logic [1:0] in_kind;

  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy4    = !v4_r || rdy_out;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;
  assign in_stall   = !rdy0;
  assign out_valid  = out_valid_r;
  assign s0_move    = v0_r & rdy1;
  assign pulse_load = v4_r & rdy_out;

  // opcode decode at the input; unknown opcodes enter as a bubble
  always_comb begin
    in_known = 1'b1;
    in_kind  = KIND_REST;
    priority if (in_data.req_type == OP_ANGLE) begin
      in_kind = KIND_ANGLE;
    end else if (in_data.req_type == OP_POSITION) begin
      in_kind = KIND_POS;
    end else if (in_data.req_type == OP_TARGET) begin
      in_kind = KIND_TGT;
    end else if (in_data.req_type == OP_REST) begin
      in_kind = KIND_REST;
    end else begin
      in_known = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid & in_known;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  // ------------------------------------------------------- stage 0: input
  logic [1:0]  kind0_r;
  logic [15:0] word0_r [2];

  always_ff @(posedge clk) begin
    if (rdy0) begin
      kind0_r    <= in_kind;
      word0_r[0] <= in_data.word_a;
      word0_r[1] <= in_data.word_b;
    end
  end

  // ------------------------------------- stage 0 -> 1: error and integral
  logic [15:0]        ball_r [2];
  logic [15:0]        tgt_r [2];
  logic signed [16:0] last_r [2];
  logic signed [31:0] acc_r [2];

  logic [15:0]        ball_nxt [2];
  logic [15:0]        tgt_nxt [2];
  logic signed [16:0] err_n [2];
  logic signed [17:0] der_n [2];
  logic signed [31:0] sum_n [2];
  logic               outside_n [2];
  logic signed [32:0] sum_wide [2];
  logic [16:0]        err_mag [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ball_nxt[a] = (kind0_r == KIND_POS) ? word0_r[a] : ball_r[a];
      tgt_nxt[a]  = (kind0_r == KIND_TGT) ? word0_r[a] : tgt_r[a];
      err_n[a]    = $signed({1'b0, tgt_nxt[a]}) - $signed({1'b0, ball_nxt[a]});
      der_n[a]    = $signed({err_n[a][16], err_n[a]}) - $signed({last_r[a][16], last_r[a]});
      sum_wide[a] = $signed({{16{err_n[a][16]}}, err_n[a]})
                  + $signed({acc_r[a][31], acc_r[a]});
      // saturate the running sum to 32 bits
      if (sum_wide[a][32] != sum_wide[a][31]) begin
        sum_n[a] = sum_wide[a][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        sum_n[a] = sum_wide[a][31:0];
      end
      err_mag[a]   = err_n[a][16] ? 17'(-err_n[a]) : 17'(err_n[a]);
      outside_n[a] = err_mag[a] > {1'b0, dead_band_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_r[0] <= '0;
      ball_r[1] <= '0;
      tgt_r[0]  <= TARGET_X_RST;
      tgt_r[1]  <= TARGET_Y_RST;
      last_r[0] <= '0;
      last_r[1] <= '0;
      acc_r[0]  <= '0;
      acc_r[1]  <= '0;
    end else if (s0_move) begin
      unique case (kind0_r)
        KIND_ANGLE: begin
          for (int a = 0; a < 2; a++) begin
            last_r[a] <= '0;
            acc_r[a]  <= '0;
          end
        end
        KIND_POS, KIND_TGT: begin
          for (int a = 0; a < 2; a++) begin
            ball_r[a] <= ball_nxt[a];
            tgt_r[a]  <= tgt_nxt[a];
            last_r[a] <= err_n[a];
            acc_r[a]  <= outside_n[a] ? sum_n[a] : 32'sd0;
          end
        end
        KIND_REST: ;
      endcase
    end
  end

  logic [1:0]         kind1_r;
  logic               ang_ok1_r;
  logic [7:0]         ang1_r;
  logic signed [16:0] err1_r [2];
  logic signed [17:0] der1_r [2];
  logic signed [31:0] sum1_r [2];
  logic               out1_r [2];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r   <= kind0_r;
      ang_ok1_r <= word0_r[0] <= 16'(MAX_ANGLE);
      ang1_r    <= word0_r[0][7:0];
      for (int a = 0; a < 2; a++) begin
        err1_r[a] <= err_n[a];
        der1_r[a] <= der_n[a];
        sum1_r[a] <= sum_n[a];
        out1_r[a] <= outside_n[a];
      end
    end
  end

  // ------------------------------------------- stage 1 -> 2: gain multiply
  logic [1:0]         kind2_r;
  logic               ang_ok2_r;
  logic [7:0]         ang2_r;
  logic               out2_r [2];
  logic signed [41:0] pp2_r [2];
  logic signed [42:0] pd2_r [2];
  logic signed [56:0] pi2_r [2];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      kind2_r   <= kind1_r;
      ang_ok2_r <= ang_ok1_r;
      ang2_r    <= ang1_r;
      for (int a = 0; a < 2; a++) begin
        out2_r[a] <= out1_r[a];
        pp2_r[a]  <= $signed({1'b0, gain_p_r[a]}) * err1_r[a];
        pd2_r[a]  <= $signed({1'b0, gain_d_r[a]}) * der1_r[a];
        pi2_r[a]  <= $signed({1'b0, gain_i_r[a]}) * sum1_r[a];
      end
    end
  end

  // ------------------------------------------------ stage 2 -> 3: sum
  logic [1:0]         kind3_r;
  logic               ang_ok3_r;
  logic [7:0]         ang3_r;
  logic               out3_r [2];
  logic signed [57:0] tot3_r [2];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      kind3_r   <= kind2_r;
      ang_ok3_r <= ang_ok2_r;
      ang3_r    <= ang2_r;
      for (int a = 0; a < 2; a++) begin
        out3_r[a] <= out2_r[a];
        tot3_r[a] <= 58'(pp2_r[a]) + 58'(pd2_r[a]) + 58'(pi2_r[a]);
      end
    end
  end

  // ------------------------------- stage 3 -> 4: truncate toward zero, clamp
  logic signed [57:0] tot_biased [2];
  logic signed [41:0] q_n [2];
  logic signed [41:0] lim_s;
  logic               dpos_n [2];
  logic [7:0]         mag_n [2];

  assign lim_s = $signed({34'd0, drive_limit_r});

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      tot_biased[a] = tot3_r[a] + (tot3_r[a][57] ? 58'(TRUNC_BIAS) : 58'd0);
      q_n[a]        = tot_biased[a][57:16];
      priority if (q_n[a] > lim_s) begin
        dpos_n[a] = 1'b1;
        mag_n[a]  = drive_limit_r;
      end else if (q_n[a] < -lim_s) begin
        dpos_n[a] = 1'b0;
        mag_n[a]  = drive_limit_r;
      end else begin
        dpos_n[a] = q_n[a] > 42'sd0;
        mag_n[a]  = q_n[a][41] ? 8'(-q_n[a]) : q_n[a][7:0];
      end
    end
  end

  logic [1:0] kind4_r;
  logic       ang_ok4_r;
  logic [7:0] ang4_r;
  logic       out4_r [2];
  logic       dpos4_r [2];
  logic [8:0] dang4_r [2];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      kind4_r   <= kind3_r;
      ang_ok4_r <= ang_ok3_r;
      ang4_r    <= ang3_r;
      for (int a = 0; a < 2; a++) begin
        out4_r[a]  <= out3_r[a];
        dpos4_r[a] <= dpos_n[a];
        dang4_r[a] <= REST_ANGLE + {1'b0, mag_n[a]};
      end
    end
  end

  // ------------------------------- stage 4 -> out: pulses and servo state
  // servo order: 0 X+, 1 Y-, 2 Y+, 3 X-
  logic [11:0] pulse_r [4];
  logic [11:0] pulse_nxt [4];
  logic [11:0] drive_pulse [2];
  logic        drive_ok [2];
  logic [1:0]  pos_idx, neg_idx;

  always_comb begin
    pos_idx = 2'd0;
    neg_idx = 2'd3;
    for (int s = 0; s < 4; s++) begin
      pulse_nxt[s] = pulse_r[s];
    end
    for (int a = 0; a < 2; a++) begin
      drive_ok[a]    = dang4_r[a] <= MAX_ANGLE;
      drive_pulse[a] = angle_to_pulse(dang4_r[a][7:0]);
    end
    unique case (kind4_r)
      KIND_ANGLE: begin
        if (ang_ok4_r) begin
          for (int s = 0; s < 4; s++) begin
            pulse_nxt[s] = angle_to_pulse(ang4_r);
          end
        end
      end
      KIND_POS, KIND_TGT: begin
        for (int a = 0; a < 2; a++) begin
          pos_idx = (a == 0) ? 2'd0 : 2'd2;
          neg_idx = (a == 0) ? 2'd3 : 2'd1;
          if (!out4_r[a]) begin
            pulse_nxt[pos_idx] = REST_PULSE;
            pulse_nxt[neg_idx] = REST_PULSE;
          end else if (dpos4_r[a]) begin
            if (drive_ok[a]) begin
              pulse_nxt[pos_idx] = drive_pulse[a];
            end
            pulse_nxt[neg_idx] = REST_PULSE;
          end else begin
            if (drive_ok[a]) begin
              pulse_nxt[neg_idx] = drive_pulse[a];
            end
            pulse_nxt[pos_idx] = REST_PULSE;
          end
        end
      end
      KIND_REST: begin
        for (int s = 0; s < 4; s++) begin
          pulse_nxt[s] = REST_PULSE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 4; s++) begin
        pulse_r[s] <= REST_PULSE;
      end
    end else if (pulse_load) begin
      for (int s = 0; s < 4; s++) begin
        pulse_r[s] <= pulse_nxt[s];
      end
    end
  end

  assign out_data.pulse_one   = pulse_r[0];
  assign out_data.pulse_two   = pulse_r[1];
  assign out_data.pulse_three = pulse_r[2];
  assign out_data.pulse_four  = pulse_r[3];

  // -------------------------------------------------------------- checks
  // servo state only moves when a result lands in the output register
  `BAL_ASSERT_NEXT(a_pulse_hold, !pulse_load, $stable(out_data))
  // an angle command clears both axes' error history
  `BAL_ASSERT_NEXT(a_angle_clear, s0_move && kind0_r == KIND_ANGLE, acc_r[0] == 32'sd0 && acc_r[1] == 32'sd0 && last_r[0] == 17'sd0 && last_r[1] == 17'sd0)
  // the input side only stalls when every stage is full
  `BAL_ASSERT_IMP(a_stall_full, in_stall, v0_r && v1_r && v2_r && v3_r && v4_r && out_valid_r)

endmodule
`default_nettype wire

// ----- bench/two_axis_pid_servo_balancer_test.sv -----
// Self-checking bench for the two-axis PID servo balancer: scoreboard, drivers, stimulus.
`timescale 1ns / 1ps
module two_axis_pid_servo_balancer_test;
  import tapsb_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  // idle margin kept after the last due result before register writes
  localparam int DRAIN_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 130;
  // one-sided run of full-scale error to build up a large integral
  localparam int SAT_RUN         = 40;

  typedef enum {PROF_RESET, PROF_MAX, PROF_MIN, PROF_RANDOM, PROF_SATURATE} cfg_profile_e;

  // Predicts the four pulse widths after each command frame and holds them
  // until the matching output transfer turns up.
  class servo_scoreboard;
    localparam int SERVO_X_POS = 0;
    localparam int SERVO_Y_NEG = 1;
    localparam int SERVO_Y_POS = 2;
    localparam int SERVO_X_NEG = 3;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    int kp_x = GAIN_P_RST, kd_x = GAIN_D_RST, ki_x = GAIN_I_RST;
    int kp_y = GAIN_P_RST, kd_y = GAIN_D_RST, ki_y = GAIN_I_RST;
    int dead_band = DEAD_BAND_RST;
    int drive_limit = DRIVE_LIMIT_RST;

    int ball_x = 0, ball_y = 0;
    int tgt_x = TARGET_X_RST, tgt_y = TARGET_Y_RST;
    int last_err_x = 0, last_err_y = 0;
    int sum_x = 0, sum_y = 0;
    logic [11:0] pulse [4] = '{default: REST_PULSE};

    out_item_t pulses_due [$];
    int errors = 0;
    int checked = 0;
    int noted = 0;

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_GAIN_P_X:    kp_x = val[23:0];
        REG_GAIN_D_X:    kd_x = val[23:0];
        REG_GAIN_I_X:    ki_x = val[23:0];
        REG_GAIN_P_Y:    kp_y = val[23:0];
        REG_GAIN_D_Y:    kd_y = val[23:0];
        REG_GAIN_I_Y:    ki_y = val[23:0];
        REG_DEAD_BAND:   dead_band = val[15:0];
        REG_DRIVE_LIMIT: drive_limit = val[7:0];
        default: ;
      endcase
    endfunction

    // out-of-range angles leave the servo where it was
    function void set_angle(int idx, longint angle);
      if (angle >= 0 && angle <= MAX_ANGLE)
        pulse[idx] = 12'(PULSE_BASE + angle * 100 / 9);
    endfunction

    function void run_axis(bit y_axis);
      longint err, der, acc, total, q;
      longint gp, gd, gi, rest;
      int pos_s, neg_s;
      rest = REST_ANGLE;
      if (y_axis) begin
        err = tgt_y - ball_y;
        der = err - last_err_y;
        acc = longint'(sum_y) + err;
        gp = kp_y; gd = kd_y; gi = ki_y;
        pos_s = SERVO_Y_POS; neg_s = SERVO_Y_NEG;
      end else begin
        err = tgt_x - ball_x;
        der = err - last_err_x;
        acc = longint'(sum_x) + err;
        gp = kp_x; gd = kd_x; gi = ki_x;
        pos_s = SERVO_X_POS; neg_s = SERVO_X_NEG;
      end
      if (acc > SUM_MAX) acc = SUM_MAX;
      if (acc < SUM_MIN) acc = SUM_MIN;
      total = gp * err + gd * der + gi * acc;
      q = total / 65536;  // truncates toward zero
      if (q > drive_limit) q = drive_limit;
      if (q < -drive_limit) q = -drive_limit;
      if (err < -dead_band || err > dead_band) begin
        if (q > 0) begin
          set_angle(pos_s, rest + q);
          set_angle(neg_s, rest);
        end else begin
          set_angle(neg_s, rest - q);
          set_angle(pos_s, rest);
        end
      end else begin
        set_angle(pos_s, rest);
        set_angle(neg_s, rest);
        acc = 0;
      end
      if (y_axis) begin
        sum_y = int'(acc);
        last_err_y = int'(err);
      end else begin
        sum_x = int'(acc);
        last_err_x = int'(err);
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t due;
      noted++;
      case (it.req_type)
        OP_ANGLE: begin
          for (int i = 0; i < 4; i++) set_angle(i, it.word_a);
          last_err_x = 0; last_err_y = 0;
          sum_x = 0; sum_y = 0;
        end
        OP_POSITION, OP_TARGET: begin
          if (it.req_type == OP_POSITION) begin
            ball_x = it.word_a;
            ball_y = it.word_b;
          end else begin
            tgt_x = it.word_a;
            tgt_y = it.word_b;
          end
          run_axis(1'b0);
          run_axis(1'b1);
        end
        OP_REST: for (int i = 0; i < 4; i++) set_angle(i, REST_ANGLE);
        default: return;
      endcase
      due.pulse_one   = pulse[SERVO_X_POS];
      due.pulse_two   = pulse[SERVO_Y_NEG];
      due.pulse_three = pulse[SERVO_Y_POS];
      due.pulse_four  = pulse[SERVO_X_NEG];
      pulses_due.push_back(due);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pulses_due.size() == 0) begin
        report($sformatf("result %h with nothing due", got));
        return;
      end
      want = pulses_due.pop_front();
      checked++;
      if (got.pulse_one !== want.pulse_one)
        report($sformatf("pulse_one %0d, want %0d", got.pulse_one, want.pulse_one));
      if (got.pulse_two !== want.pulse_two)
        report($sformatf("pulse_two %0d, want %0d", got.pulse_two, want.pulse_two));
      if (got.pulse_three !== want.pulse_three)
        report($sformatf("pulse_three %0d, want %0d", got.pulse_three, want.pulse_three));
      if (got.pulse_four !== want.pulse_four)
        report($sformatf("pulse_four %0d, want %0d", got.pulse_four, want.pulse_four));
    endtask

    function int pending();
      return pulses_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals. Everything the bench drives starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  servo_scoreboard sb = new;
  int  cycle_count = 0;
  int  stall_run = 0;
  int  n_settings = 0;
  bit  calm = 1'b0;  // when set, the sender leaves no gaps and no new stall run starts

  two_axis_pid_servo_balancer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop in case a handshake never completes.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Gap lengths: mostly short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stall runs, none started while calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run <= pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every output transfer goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one frame and holds it until the transfer; the scoreboard is fed
  // from here so that its order against the drain checks is fixed.
  task automatic send_item(in_item_t it);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic send_cmd(logic [7:0] op, logic [15:0] a, logic [15:0] b);
    in_item_t it;
    it = '{req_type: op, word_a: a, word_b: b};
    send_item(it);
  endtask

  // Sender holds off until every due result has been seen (it always waits on a clock
  // edge first, so in_valid is never lowered and raised in one step).
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Idle point for register writes: nothing due and the pipe flushed of frames
  // that give no result.
  task automatic wait_drained();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, then access; the register takes the value at the access edge.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFF_FFFF;
    if (r < 4) return $urandom_range(0, 32'hFF_FFFF);
    return $urandom_range(0, 131072);
  endfunction

  task automatic apply_profile(cfg_profile_e prof);
    logic [31:0] vals [8];
    int r;
    wait_drained();
    case (prof)
      PROF_RESET: begin
        vals[REG_GAIN_P_X] = GAIN_P_RST; vals[REG_GAIN_D_X] = GAIN_D_RST;
        vals[REG_GAIN_I_X] = GAIN_I_RST; vals[REG_GAIN_P_Y] = GAIN_P_RST;
        vals[REG_GAIN_D_Y] = GAIN_D_RST; vals[REG_GAIN_I_Y] = GAIN_I_RST;
        vals[REG_DEAD_BAND] = DEAD_BAND_RST; vals[REG_DRIVE_LIMIT] = DRIVE_LIMIT_RST;
      end
      PROF_MAX: begin
        // full gains, no dead band, limit wide enough to overrun 180 degrees
        for (int i = REG_GAIN_P_X; i <= REG_GAIN_I_Y; i++) vals[i] = 32'hFF_FFFF;
        vals[REG_DEAD_BAND] = 32'd0;
        vals[REG_DRIVE_LIMIT] = 32'hFF;
      end
      PROF_MIN: begin
        for (int i = REG_GAIN_P_X; i <= REG_GAIN_I_Y; i++) vals[i] = 32'd0;
        vals[REG_DEAD_BAND] = 32'hFFFF;
        vals[REG_DRIVE_LIMIT] = 32'd0;
      end
      PROF_SATURATE: begin
        // integral gain at full scale so the running sum dominates
        vals[REG_GAIN_P_X] = GAIN_P_RST; vals[REG_GAIN_D_X] = GAIN_D_RST;
        vals[REG_GAIN_I_X] = 32'hFF_FFFF; vals[REG_GAIN_P_Y] = GAIN_P_RST;
        vals[REG_GAIN_D_Y] = GAIN_D_RST; vals[REG_GAIN_I_Y] = 32'hFF_FFFF;
        vals[REG_DEAD_BAND] = DEAD_BAND_RST; vals[REG_DRIVE_LIMIT] = 32'd175;
      end
      default: begin
        for (int i = REG_GAIN_P_X; i <= REG_GAIN_I_Y; i++) vals[i] = rand_gain();
        r = $urandom_range(0, 19);
        if (r < 2) vals[REG_DEAD_BAND] = 32'd0;
        else if (r < 3) vals[REG_DEAD_BAND] = 32'hFFFF;
        else if (r < 5) vals[REG_DEAD_BAND] = $urandom_range(0, 32'hFFFF);
        else vals[REG_DEAD_BAND] = $urandom_range(0, 100);
        r = $urandom_range(0, 19);
        if (r < 2) vals[REG_DRIVE_LIMIT] = 32'd0;
        else if (r < 5) vals[REG_DRIVE_LIMIT] = $urandom_range(176, 255);
        else vals[REG_DRIVE_LIMIT] = $urandom_range(1, 175);
      end
    endcase
    for (int i = REG_GAIN_P_X; i <= REG_DRIVE_LIMIT; i++) cfg_write(3'(i), vals[i]);
    n_settings++;
  endtask

  function automatic logic [15:0] near(int centre, int span);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(centre + $urandom_range(0, 2 * span) - span);
  endfunction

  // Mostly ball positions wandering around the target, as a tracking loop
  // would see them; the rest targets, angles, rests and junk opcodes.
  function automatic in_item_t make_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.word_a = 16'($urandom);
    it.word_b = 16'($urandom);
    if (r < 45) begin
      it.req_type = OP_POSITION;
      it.word_a = near(sb.tgt_x, 100);
      it.word_b = near(sb.tgt_y, 100);
    end else if (r < 58) begin
      it.req_type = OP_TARGET;
      it.word_a = near(TARGET_X_RST, 300);
      it.word_b = near(TARGET_Y_RST, 300);
    end else if (r < 72) begin
      it.req_type = OP_ANGLE;
      r = $urandom_range(0, 9);
      if (r < 7) it.word_a = 16'($urandom_range(0, MAX_ANGLE));
      else if (r < 9) it.word_a = 16'($urandom_range(MAX_ANGLE + 1, MAX_ANGLE + 10));
    end else if (r < 82) begin
      it.req_type = OP_REST;
    end else if (r < 90) begin
      do it.req_type = 8'($urandom);
      while (it.req_type inside {OP_ANGLE, OP_POSITION, OP_TARGET, OP_REST});
    end else begin
      it.req_type = OP_POSITION;
    end
    return it;
  endfunction

  cfg_profile_e phase_plan [6] = '{PROF_RESET, PROF_RANDOM, PROF_RANDOM,
                                   PROF_MAX, PROF_RANDOM, PROF_RANDOM};

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames against the reset settings.
    send_cmd(OP_REST, 16'h0000, 16'h0000);
    send_cmd(OP_ANGLE, 16'd0, 16'hFFFF);
    send_cmd(OP_ANGLE, 16'd180, 16'h0000);
    send_cmd(OP_ANGLE, 16'd181, 16'h0000);      // past 180: pulses stay, state clears
    send_cmd(OP_ANGLE, 16'hFFFF, 16'hFFFF);
    send_cmd(8'h00, 16'hFFFF, 16'hFFFF);        // unknown opcodes: swallowed
    send_cmd(8'hFF, 16'h0000, 16'h0000);
    send_cmd(OP_POSITION, 16'd0, 16'd0);
    send_cmd(OP_POSITION, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_POSITION, 16'd290, 16'd210);    // error exactly at the dead band
    send_cmd(OP_POSITION, 16'd289, 16'd209);    // one past it
    send_cmd(OP_POSITION, 16'd350, 16'd270);    // negative edge of the band
    send_cmd(OP_TARGET, 16'hFFFF, 16'h0000);
    send_cmd(OP_TARGET, 16'h0000, 16'hFFFF);
    send_cmd(OP_REST, 16'hFFFF, 16'hFFFF);      // rest keeps errors and integrals
    send_cmd(OP_POSITION, 16'd100, 16'd100);
    send_cmd(8'd49, 16'd320, 16'd240);

    // Drive angle beyond 180 on the active servo with a wide limit.
    apply_profile(PROF_MAX);
    send_cmd(OP_ANGLE, 16'd90, 16'd0);
    send_cmd(OP_TARGET, 16'd320, 16'd240);
    send_cmd(OP_POSITION, 16'd0, 16'd0);
    send_cmd(OP_POSITION, 16'hFFFF, 16'hFFFF);

    // Zero gains, zero limit, dead band covering everything.
    apply_profile(PROF_MIN);
    send_cmd(OP_POSITION, 16'd0, 16'd0);
    send_cmd(OP_TARGET, 16'hFFFF, 16'hFFFF);

    // Integral build-up, both signs, at full rate.
    apply_profile(PROF_SATURATE);
    calm = 1'b1;
    send_cmd(OP_ANGLE, 16'd90, 16'd0);
    send_cmd(OP_TARGET, 16'hFFFF, 16'hFFFF);
    repeat (SAT_RUN) send_cmd(OP_POSITION, 16'd0, 16'd0);
    send_cmd(OP_ANGLE, 16'd90, 16'd0);
    send_cmd(OP_TARGET, 16'd0, 16'd0);
    repeat (SAT_RUN) send_cmd(OP_POSITION, 16'hFFFF, 16'hFFFF);
    calm = 1'b0;

    // Random phases, each under its own settings.
    for (int p = 0; p < 6; p++) begin
      apply_profile(phase_plan[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) hold_until_drained();
        send_item(make_item());
      end
      calm = 1'b0;
    end

    wait_drained();
    $display("Checked %0d pulse results from %0d command transfers under %0d settings,",
             sb.checked, sb.noted, n_settings);
    $display("including dead-band edges, angle overrun and long one-sided integral runs.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tapsb_pkg.sv
hw/rtl/two_axis_pid_servo_balancer.sv
bench/two_axis_pid_servo_balancer_test.sv
